@@ hw/rtl/icr_pkg.sv @@
// Shared types and constants for the interrupt controller register block.
`default_nettype none

package icr_pkg;

    localparam int unsigned NUM_LINES = 32;
    localparam int unsigned LINE_IDX_W = $clog2(NUM_LINES);
    localparam logic [31:0] VECTOR_NONE = 32'hffff_ffff;

    typedef enum logic [1:0] {
        KIND_READ    = 2'd0,
        KIND_WRITE   = 2'd1,
        KIND_TRIGGER = 2'd2
    } kind_t;

    typedef enum logic [2:0] {
        SEL_STATUS     = 3'd0,
        SEL_PENDING    = 3'd1,
        SEL_ENABLE     = 3'd2,
        SEL_ACK        = 3'd3,
        SEL_SET_ENABLE = 3'd4,
        SEL_CLR_ENABLE = 3'd5,
        SEL_VECTOR     = 3'd6,
        SEL_MASTER     = 3'd7
    } sel_t;

    typedef struct packed {
        logic [1:0]  kind;
        logic [2:0]  reg_select;
        logic [31:0] write_value;
        logic [5:0]  line_number;
    } item_t;

    typedef struct packed {
        logic [31:0] read_value;
        logic        irq_out;
    } result_t;

endpackage

`default_nettype wire

@@ hw/rtl/icr_in_stage.sv @@
// Input register stage: holds one accepted beat until the execute step takes it.
`default_nettype none

module icr_in_stage
(
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          in_valid,
    output      logic          in_ready,
    input  wire icr_pkg::item_t in_item,
    input  wire logic          take,
    output      logic          held_valid,
    output      icr_pkg::item_t held_item
);

    logic           valid_reg;
    icr_pkg::item_t item_reg;

    // accept while empty or while the held beat leaves this cycle
    assign in_ready = !valid_reg || take;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            item_reg <= in_item;
        end
    end

    assign held_valid = valid_reg;
    assign held_item  = item_reg;

endmodule

`default_nettype wire

@@ hw/rtl/icr_exec.sv @@
// Register file and execute logic: status, enable and master words, read mux, vector.
`default_nettype none

module icr_exec
(
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            advance,
    input  wire icr_pkg::item_t  item,
    output      icr_pkg::result_t result,
    output      logic            level
);

    logic [31:0] status_reg;
    logic [31:0] status_next;
    logic [31:0] enable_reg;
    logic [31:0] enable_next;
    logic [31:0] master_reg;
    logic [31:0] master_next;
    logic [31:0] active;
    logic [31:0] vector_value;
    logic [31:0] rd_value;
    logic [icr_pkg::LINE_IDX_W-1:0] low_idx;

    function automatic logic [icr_pkg::LINE_IDX_W-1:0] lowest_set(input logic [31:0] bits);
        logic [icr_pkg::LINE_IDX_W-1:0] idx;
        idx = '0;
        for (int i = 31; i >= 0; i--)
        begin
            if (bits[i])
            begin
                idx = icr_pkg::LINE_IDX_W'(i);
            end
        end
        return idx;
    endfunction

    assign active  = status_reg & enable_reg;
    assign low_idx = lowest_set(active);
    assign vector_value = (|active) ? {{(32 - icr_pkg::LINE_IDX_W){1'b0}}, low_idx}
                                    : icr_pkg::VECTOR_NONE;

    always_comb
    begin
        status_next = status_reg;
        enable_next = enable_reg;
        master_next = master_reg;
        rd_value    = '0;
        case (item.kind)
            icr_pkg::KIND_READ:
            begin
                case (item.reg_select)
                    icr_pkg::SEL_STATUS:  rd_value = status_reg;
                    icr_pkg::SEL_PENDING: rd_value = active;
                    icr_pkg::SEL_ENABLE:  rd_value = enable_reg;
                    icr_pkg::SEL_VECTOR:  rd_value = vector_value;
                    icr_pkg::SEL_MASTER:  rd_value = master_reg;
                    default:              rd_value = '0;
                endcase
            end
            icr_pkg::KIND_WRITE:
            begin
                case (item.reg_select)
                    icr_pkg::SEL_STATUS:     status_next = item.write_value;
                    icr_pkg::SEL_ENABLE:     enable_next = item.write_value;
                    icr_pkg::SEL_ACK:        status_next = status_reg & ~item.write_value;
                    icr_pkg::SEL_SET_ENABLE: enable_next = enable_reg | item.write_value;
                    icr_pkg::SEL_CLR_ENABLE: enable_next = enable_reg & ~item.write_value;
                    icr_pkg::SEL_MASTER:     master_next = item.write_value;
                    default:                 master_next = master_reg;
                endcase
            end
            icr_pkg::KIND_TRIGGER:
            begin
                // drop lines 32 and up
                if (!item.line_number[5])
                begin
                    status_next = status_reg
                                | (32'd1 << item.line_number[icr_pkg::LINE_IDX_W-1:0]);
                end
            end
            default:
            begin
                rd_value = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            status_reg <= '0;
            enable_reg <= '0;
            master_reg <= '0;
        end
        else if (advance)
        begin
            status_reg <= status_next;
            enable_reg <= enable_next;
            master_reg <= master_next;
        end
    end

    assign result.read_value = rd_value;
    assign result.irq_out    = |(status_next & enable_next);
    assign level             = |active;

endmodule

`default_nettype wire

@@ hw/rtl/icr_out_stage.sv @@
// Result register stage: holds one result beat until the receiver takes it.
`default_nettype none

module icr_out_stage
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             load,
    input  wire icr_pkg::result_t load_result,
    output      logic             can_load,
    output      logic             out_valid,
    input  wire logic             out_ready,
    output      icr_pkg::result_t out_result
);

    logic             valid_reg;
    icr_pkg::result_t result_reg;

    assign can_load = !valid_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (can_load)
        begin
            valid_reg <= load;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            result_reg <= load_result;
        end
    end

    assign out_valid  = valid_reg;
    assign out_result = result_reg;

endmodule

`default_nettype wire

@@ hw/rtl/interrupt_controller_registers_core.sv @@
// Top level of the 32-source interrupt controller register block.
//
// Usage:
//   Input channel (in_valid/in_ready) carries one beat per bus access or
//   line trigger: kind selects read, write or trigger; reg_select picks the
//   register; write_value is write data; line_number is the line to set.
//   Output channel (out_valid/out_ready) returns one beat per input beat,
//   in order: read_value (zero unless a read) and irq_out, the request
//   level after that beat took effect.
//   Path: an accepted beat waits in the input register, then executes and
//   loads into the result register once that register is free.
//   Throughput: one beat per cycle unless stalled; the input register
//   feeds the execute logic and the state words update in the same cycle
//   the result register loads, so each beat sees every earlier beat's effect.
//   Reset: status, enable and master words clear, both stages empty,
//   irq_out reads low on the first result.
//   Stall: when out_ready is low the result holds; one more beat waits in
//   the input register, after which in_ready drops until the output drains.
`default_nettype none

module interrupt_controller_registers_core
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output      logic        in_ready,
    input  wire logic [1:0]  kind,
    input  wire logic [2:0]  reg_select,
    input  wire logic [31:0] write_value,
    input  wire logic [5:0]  line_number,
    output      logic        out_valid,
    input  wire logic        out_ready,
    output      logic [31:0] read_value,
    output      logic        irq_out
);

    icr_pkg::item_t   in_item;
    icr_pkg::item_t   held_item;
    icr_pkg::result_t exec_result;
    icr_pkg::result_t out_result;
    logic             held_valid;
    logic             can_load;
    logic             advance;
    logic             level;

    assign in_item.kind        = kind;
    assign in_item.reg_select  = reg_select;
    assign in_item.write_value = write_value;
    assign in_item.line_number = line_number;

    // move the held beat through execute when the result register frees up
    assign advance = held_valid && can_load;

    icr_in_stage u_in_stage
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .in_item    (in_item),
        .take       (advance),
        .held_valid (held_valid),
        .held_item  (held_item)
    );

    // state words commit on advance; result comes from the next-state values
    icr_exec u_exec
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .advance (advance),
        .item    (held_item),
        .result  (exec_result),
        .level   (level)
    );

    icr_out_stage u_out_stage
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .load        (advance),
        .load_result (exec_result),
        .can_load    (can_load),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .out_result  (out_result)
    );

    assign read_value = out_result.read_value;
    assign irq_out    = out_result.irq_out;

    // an executed beat always lands in the result register
    a_advance_fills_out: assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> out_valid)
        else $error("executed beat did not reach result register");

    // irq in a fresh result matches the committed state words
    a_irq_tracks_state: assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> (irq_out == level))
        else $error("irq_out disagrees with committed state");

    // non-read beats return zero data
    a_nonread_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && (held_item.kind != icr_pkg::KIND_READ)) |=> (read_value == '0))
        else $error("non-read beat returned data");

    // vector read with nothing active returns all ones
    a_vector_none: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && (held_item.kind == icr_pkg::KIND_READ)
                 && (held_item.reg_select == icr_pkg::SEL_VECTOR) && !level)
        |=> (read_value == icr_pkg::VECTOR_NONE))
        else $error("empty vector read did not return all ones");

endmodule

`default_nettype wire
